// ----- hw/rtl/phgm_pkg.sv -----
`default_nettype none
package phgm_pkg;

    localparam int COORD_W = 17;   // x offset and z, below GRID_SIZE*CELL_MM
    localparam int ROW_W   = 10;   // row / col index, up to 1024 cells
    localparam int SUM_W   = 35;
    localparam int CNT_W   = 18;
    localparam int DIV_W   = 35;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;

    localparam logic [1:0] ST_CLEARED = 2'd0;
    localparam logic [1:0] ST_BINNED  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;
    localparam logic [1:0] ST_READ    = 2'd3;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_ADD      = 3'd1,
        OP_OUTSIDE  = 3'd2,
        OP_READ     = 3'd3,
        OP_READ_OOR = 3'd4
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] x_off;
        logic [COORD_W-1:0] z;
        logic signed [15:0] y;
        logic [8:0]         row;
        logic [8:0]         col;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [8:0]         row;
        logic [8:0]         col;
        logic [15:0]        mean;
        logic [CNT_W-1:0]   count;
        logic               obstacle;
    } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/phgm_front.sv -----
`default_nettype none
module phgm_front #(
    parameter int GRID_SIZE = 400,
    parameter int CELL_MM   = 10
) (
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         q_full,
    output logic              q_push,
    output phgm_pkg::cmd_t    q_cmd
);
    import phgm_pkg::*;

    localparam int HALF_LO = (GRID_SIZE / 2) * CELL_MM;
    localparam int HALF_HI = (GRID_SIZE - GRID_SIZE / 2) * CELL_MM;
    localparam int SPAN    = GRID_SIZE * CELL_MM;
    localparam logic signed [18:0] HLO = 19'(HALF_LO);
    localparam logic signed [18:0] HHI = 19'(HALF_HI);
    localparam logic signed [18:0] SPN = 19'(SPAN);
    localparam logic [10:0]        GSZ = 11'(GRID_SIZE);

    logic signed [18:0] xs, zs, xo;
    logic               in_area;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        xs = {{3{s_tdata[15]}}, s_tdata[15:0]};
        zs = {{3{s_tdata[47]}}, s_tdata[47:32]};
        xo = xs + HLO;
        in_area = (xs > -HLO) && (xs < HHI) && (zs > 19'sd0) && (zs < SPN);
        q_cmd.x_off = COORD_W'(xo);
        q_cmd.z     = COORD_W'(zs);
        q_cmd.y     = s_tdata[31:16];
        q_cmd.row   = s_tdata[56:48];
        q_cmd.col   = s_tdata[65:57];
        if (s_tuser == MODE_CLEAR) begin
            q_cmd.op = OP_CLEAR;
        end else if (s_tuser == MODE_ADD) begin
            q_cmd.op = in_area ? OP_ADD : OP_OUTSIDE;
        end else if (({2'b0, s_tdata[56:48]} >= GSZ) || ({2'b0, s_tdata[65:57]} >= GSZ)) begin
            q_cmd.op = OP_READ_OOR;
        end else begin
            q_cmd.op = OP_READ;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/phgm_queue.sv -----
`default_nettype none
module phgm_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire phgm_pkg::cmd_t  push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output phgm_pkg::cmd_t       head
);
    import phgm_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/phgm_div.sv -----
`default_nettype none
module phgm_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [phgm_pkg::DIV_W-1:0]    dividend,
    input  wire logic [phgm_pkg::CNT_W-1:0]    divisor,
    output logic                               busy,
    output logic                               done,
    output logic [phgm_pkg::DIV_W-1:0]         quotient
);
    import phgm_pkg::*;

    logic [DIV_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg, dvs_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg, done_reg;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W+1:0] diff;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // one restoring step per cycle
    always_comb begin
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        diff   = {1'b0, rem_sh} - {2'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= 6'(DIV_W - 1);
        end else if (busy_reg) begin
            if (!diff[CNT_W+1]) begin
                rem_reg <= diff[CNT_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[CNT_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && cnt_reg == 6'd0) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end else begin
            done_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/phgm_back.sv -----
`default_nettype none
module phgm_back #(
    parameter int GRID_SIZE = 400,
    parameter int CELL_MM   = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire phgm_pkg::cmd_t     q_cmd,
    output logic                    q_pop,
    input  wire logic [15:0]        threshold,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output phgm_pkg::res_t          m_res
);
    import phgm_pkg::*;

    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int ENT_W = SUM_W + CNT_W;
    // binning by reciprocal multiply, exact for offsets below 2^17
    localparam int RCP_SH = 24;
    localparam int RCP_W  = RCP_SH + 1;
    localparam int PRD_W  = COORD_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP = RCP_W'((2**RCP_SH + CELL_MM - 1) / CELL_MM);

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DROW  = 8'b0000_0100,
        S_DCOL  = 8'b0000_1000,
        S_RD    = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_DMEAN = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [ROW_W-1:0]        row_reg, row_next, col_reg, col_next;
    logic [IDX_W-1:0]        clr_idx_reg, clr_idx_next, idx;
    logic                    clr_item_reg, clr_item_next;
    logic [CNT_W-1:0]        ent_cnt_reg, ent_cnt_next;
    logic                    neg_reg, neg_next;
    res_t                    pend_reg, pend_next, m_res_reg;
    logic                    m_valid_reg, load_out;

    logic [ENT_W-1:0]        mem [DEPTH];
    logic [ENT_W-1:0]        rd_data_reg;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [ENT_W-1:0]        mem_wdata;

    logic                    div_start, div_busy, div_done;
    logic [DIV_W-1:0]        div_a, div_q;
    logic [CNT_W-1:0]        div_b;

    logic [COORD_W-1:0]      bin_in;
    logic [PRD_W-1:0]        bin_prod;

    logic signed [SUM_W-1:0] rd_sum, new_sum;
    logic [CNT_W-1:0]        rd_cnt, new_cnt;
    logic signed [16:0]      mean17;

    phgm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign idx     = IDX_W'(32'(row_reg) * GRID_SIZE + 32'(col_reg));
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
    assign load_out = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        rd_sum = rd_data_reg[ENT_W-1:CNT_W];
        rd_cnt = rd_data_reg[CNT_W-1:0];
        if (cmd_reg.op == OP_ADD && rd_cnt != CNT_MAX) begin
            new_sum = rd_sum + {{(SUM_W-16){cmd_reg.y[15]}}, cmd_reg.y};
            new_cnt = rd_cnt + 1'b1;
        end else begin
            new_sum = rd_sum;
            new_cnt = rd_cnt;
        end
        mean17 = neg_reg ? -$signed(div_q[16:0]) : $signed(div_q[16:0]);
        // one shared multiplier: z for the row, x offset for the column
        bin_in   = (state_reg == S_DROW) ? cmd_reg.z : cmd_reg.x_off;
        bin_prod = PRD_W'(bin_in) * PRD_W'(RCP);
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        clr_idx_next  = clr_idx_reg;
        clr_item_next = clr_item_reg;
        ent_cnt_next  = ent_cnt_reg;
        neg_next      = neg_reg;
        pend_next     = pend_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = idx;
        mem_wdata     = {new_sum, new_cnt};
        div_start     = 1'b0;
        div_a         = '0;
        div_b         = new_cnt;
        unique case (state_reg)
            S_CLR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(DEPTH - 1)) begin
                    pend_next  = '0;
                    state_next = clr_item_reg ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    pend_next = '0;
                    unique case (q_cmd.op)
                        OP_CLEAR: begin
                            clr_idx_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        OP_ADD: begin
                            state_next = S_DROW;
                        end
                        OP_OUTSIDE: begin
                            pend_next.status = ST_OUTSIDE;
                            state_next       = S_OUT;
                        end
                        OP_READ: begin
                            row_next   = ROW_W'(q_cmd.row);
                            col_next   = ROW_W'(q_cmd.col);
                            state_next = S_RD;
                        end
                        default: begin
                            pend_next.status = ST_READ;
                            pend_next.row    = q_cmd.row;
                            pend_next.col    = q_cmd.col;
                            state_next       = S_OUT;
                        end
                    endcase
                end
            end
            S_DROW: begin
                row_next   = bin_prod[RCP_SH +: ROW_W];
                state_next = S_DCOL;
            end
            S_DCOL: begin
                col_next   = bin_prod[RCP_SH +: ROW_W];
                state_next = S_RD;
            end
            S_RD: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                mem_we           = (cmd_reg.op == OP_ADD);
                ent_cnt_next     = new_cnt;
                neg_next         = new_sum[SUM_W-1];
                pend_next.status = (cmd_reg.op == OP_ADD) ? ST_BINNED : ST_READ;
                pend_next.row    = row_reg[8:0];
                pend_next.col    = col_reg[8:0];
                pend_next.count  = new_cnt;
                if (new_cnt == '0) begin
                    state_next = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    div_a      = new_sum[SUM_W-1] ? DIV_W'(-new_sum) : DIV_W'(new_sum);
                    div_b      = new_cnt;
                    state_next = S_DMEAN;
                end
            end
            S_DMEAN: begin
                if (div_done) begin
                    pend_next.mean     = mean17[15:0];
                    pend_next.obstacle = mean17 > $signed({threshold[15], threshold});
                    state_next         = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    clr_item_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[idx];
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        ent_cnt_reg <= ent_cnt_next;
        neg_reg     <= neg_next;
        pend_reg    <= pend_next;
        if (load_out) begin
            m_res_reg <= pend_reg;
        end
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_idx_reg  <= '0;
            clr_item_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            clr_item_reg <= clr_item_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped outside idle");
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_no_zero_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DMEAN |-> ent_cnt_reg != '0)
        else $error("mean division by zero count");
    a_clr_no_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> !load_out)
        else $error("result loaded during clear sweep");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/point_height_grid_map.sv -----
// Height map over a GRID_SIZE x GRID_SIZE cell store, one sum/count entry per cell.
// Path, accept to m_tvalid: an add has two reciprocal-multiply binning steps,
// read-modify-write and the mean divide; a read skips binning, an empty cell skips
// the divide, an outside add or an out-of-range read goes straight out. The back end takes
// one item at a time, a 2-item queue takes items; clear item and reset both sweep the store.
// aresetn is synchronous active low; threshold resets to 100.
`default_nettype none
module point_height_grid_map #(
    parameter int GRID_SIZE = 400,
    parameter int CELL_MM   = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // x_mm, y_mm, z_mm, read_row, read_col, zero pad
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // cell_row, cell_col, mean_mm, point_count, obstacle, pad
    output logic [1:0]       m_tuser,   // status
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata  // obstacle_threshold_mm
);
    import phgm_pkg::*;

    logic [15:0] thr_reg;
    logic        q_full, q_push, q_pop, q_valid;
    cmd_t        push_cmd, head_cmd;
    res_t        res;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 16'd100;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // front: decode mode, area test, read range test
    phgm_front #(.GRID_SIZE(GRID_SIZE), .CELL_MM(CELL_MM)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    phgm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head_cmd)
    );

    // back: binning, cell read-modify-write, mean, output register
    phgm_back #(.GRID_SIZE(GRID_SIZE), .CELL_MM(CELL_MM)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .threshold (thr_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {3'b0, res.obstacle, res.count, res.mean, res.col, res.row};

endmodule
`default_nettype wire

// ----- tb/sv/point_height_grid_map_test.sv -----
`default_nettype none
module point_height_grid_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    import phgm_pkg::*;

    localparam int GRID  = 400;
    localparam int CELLS = GRID * GRID;
    localparam int WATCHDOG_LIMIT = 800000;   // several full clear sweeps plus slack
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_READ3 = 2'd3;
    localparam logic [17:0] COUNT_SAT = 18'h3FFFF;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;    // x_mm, y_mm, z_mm, read_row, read_col, zero pad
    logic [1:0]  s_tuser;    // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // cell_row, cell_col, mean_mm, point_count, obstacle, pad
    logic [1:0]  m_tuser;    // status
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    point_height_grid_map uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [8:0]  rrow;
        logic [8:0]  rcol;
    } point_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  row;
        logic [8:0]  col;
        logic [15:0] mean;
        logic [17:0] count;
        logic        obstacle;
    } cell_report_t;

    // Local copy of the map. Sparse: only touched cells are kept.
    longint       height_sum[int];
    int           height_cnt[int];
    logic signed [15:0] threshold;

    cell_report_t pending_reports[$];
    int           errors;
    int           idle_cycles;
    bit           hold_off;
    bit           stim_done;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // floor division by the cell size
    function automatic int floor_cell(int a);
        int q;
        q = a / 10;
        if ((a % 10) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic cell_report_t cell_readout(int row, int col, logic [1:0] st);
        cell_report_t r;
        int idx;
        longint m;
        idx = row * GRID + col;
        r = '0;
        r.status = st;
        r.row = row[8:0];
        r.col = col[8:0];
        if (height_cnt.exists(idx) && height_cnt[idx] != 0) begin
            m = height_sum[idx] / longint'(height_cnt[idx]);
            r.mean = m[15:0];
            r.count = height_cnt[idx][17:0];
            r.obstacle = (m > longint'(threshold));
        end
        return r;
    endfunction

    // Advances the local map by one item, returns the report it causes.
    function automatic cell_report_t map_update(point_cmd_t c);
        cell_report_t r;
        int x, y, z, row, col, idx;
        r = '0;
        if (c.mode == MODE_CLEAR) begin
            height_sum.delete();
            height_cnt.delete();
            r.status = ST_CLEARED;
        end else if (c.mode == MODE_ADD) begin
            x = int'($signed(c.x));
            y = int'($signed(c.y));
            z = int'($signed(c.z));
            if (!(x > -2000 && x < 2000 && z > 0 && z < 4000)) begin
                r.status = ST_OUTSIDE;
            end else begin
                row = floor_cell(z);
                col = floor_cell(x) + GRID / 2;
                idx = row * GRID + col;
                if (!height_cnt.exists(idx)) begin
                    height_cnt[idx] = 0;
                    height_sum[idx] = 0;
                end
                if (height_cnt[idx] < int'(COUNT_SAT)) begin
                    height_sum[idx] += y;
                    height_cnt[idx]++;
                end
                r = cell_readout(row, col, ST_BINNED);
            end
        end else begin
            if (c.rrow >= GRID || c.rcol >= GRID) begin
                r.status = ST_READ;
                r.row = c.rrow;
                r.col = c.rcol;
            end else begin
                r = cell_readout(int'(c.rrow), int'(c.rcol), ST_READ);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Push one item through the input channel, with a random gap first when gap is set.
    task automatic send_item(point_cmd_t c, bit gap);
        int g;
        g = gap ? $urandom_range(1, 4) : 0;
        repeat (g) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {9'd0, c.rcol, c.rrow, c.z, c.y, c.x};
        s_tuser  <= c.mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_reports.push_back(map_update(c));
        if (gap) s_tvalid <= 1'b0;
    endtask

    task automatic drain_then_config(logic [15:0] value);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);    // let any trailing add or read settle
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        threshold = value;
    endtask

    function automatic point_cmd_t add_cmd(int x, int y, int z);
        point_cmd_t c;
        c = '0;
        c.mode = MODE_ADD;
        c.x = x[15:0];
        c.y = y[15:0];
        c.z = z[15:0];
        return c;
    endfunction

    function automatic point_cmd_t read_cmd(int row, int col, logic [1:0] m);
        point_cmd_t c;
        c = '0;
        c.mode = m;
        c.rrow = row[8:0];
        c.rcol = col[8:0];
        return c;
    endfunction

    // Random item biased toward a small hot patch so cells collect many points.
    function automatic point_cmd_t random_cmd();
        point_cmd_t c;
        int sel;
        sel = $urandom_range(0, 99);
        c = '0;
        c.x = 16'($urandom);
        c.y = 16'($urandom);
        c.z = 16'($urandom);
        c.rrow = 9'($urandom);
        c.rcol = 9'($urandom);
        if (sel < 2) begin
            c.mode = MODE_CLEAR;
        end else if (sel < 55) begin
            c.mode = MODE_ADD;
            if (sel < 45) begin
                c.x = 16'($urandom_range(0, 39)) - 16'd20;
                c.z = 16'($urandom_range(1, 30));
                if ($urandom_range(0, 3) == 0) c.y = 16'($urandom_range(0, 400)) - 16'd200;
            end else if (sel < 50) begin
                c.x = 16'($urandom_range(0, 3998)) - 16'd1999;
                c.z = 16'($urandom_range(1, 3999));
            end
        end else begin
            c.mode = (sel < 60) ? MODE_READ3 : MODE_READ;
            if (sel < 90) begin
                c.rrow = 9'($urandom_range(0, 3));
                c.rcol = 9'($urandom_range(198, 201));
            end
        end
        return c;
    endfunction

    // Directed table: expectations typed only where obvious; others come from the map.
    point_cmd_t   dir_cmd[$];
    bit           dir_has_want[$];
    cell_report_t dir_want[$];

    task automatic add_row(point_cmd_t c, bit has, cell_report_t w);
        dir_cmd.push_back(c);
        dir_has_want.push_back(has);
        dir_want.push_back(w);
    endtask

    function automatic cell_report_t status_only(logic [1:0] st, int row, int col);
        cell_report_t r;
        r = '0;
        r.status = st;
        r.row = row[8:0];
        r.col = col[8:0];
        return r;
    endfunction

    // Stimulus
    initial begin
        point_cmd_t c;
        cell_report_t w;
        int burst;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        threshold = 16'sd100;
        errors    = 0;
        stim_done = 1'b0;
        hold_off  = 1'b0;
        w = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        add_row(read_cmd(0, 0, MODE_READ), 1, status_only(ST_READ, 0, 0));
        add_row(read_cmd(511, 511, MODE_READ), 1, status_only(ST_READ, 511, 511));
        add_row(read_cmd(400, 5, MODE_READ3), 1, status_only(ST_READ, 400, 5));
        add_row(read_cmd(399, 399, MODE_READ3), 1, status_only(ST_READ, 399, 399));
        add_row(add_cmd(-2000, 5, 10), 1, status_only(ST_OUTSIDE, 0, 0));
        add_row(add_cmd(2000, 5, 10), 1, status_only(ST_OUTSIDE, 0, 0));
        add_row(add_cmd(0, 5, 0), 1, status_only(ST_OUTSIDE, 0, 0));
        add_row(add_cmd(0, 5, 4000), 1, status_only(ST_OUTSIDE, 0, 0));
        add_row(add_cmd(-32768, 0, -32768), 1, status_only(ST_OUTSIDE, 0, 0));
        add_row(add_cmd(32767, -1, 32767), 1, status_only(ST_OUTSIDE, 0, 0));
        add_row(add_cmd(-1999, 32767, 1), 0, w);
        add_row(add_cmd(1999, -32768, 3999), 0, w);
        add_row(add_cmd(-1, 101, 1), 0, w);
        add_row(add_cmd(-9, -50, 9), 0, w);
        add_row(add_cmd(0, 100, 5), 0, w);
        add_row(add_cmd(9, 101, 9), 0, w);
        add_row(read_cmd(0, 199, MODE_READ), 0, w);
        add_row(read_cmd(0, 200, MODE_READ3), 0, w);
        add_row(read_cmd(0, 0, MODE_READ), 0, w);
        add_row(read_cmd(399, 399, MODE_READ), 0, w);
        add_row('0, 1, status_only(ST_CLEARED, 0, 0));
        add_row(read_cmd(0, 200, MODE_READ), 1, status_only(ST_READ, 0, 200));

        while (!s_tready) @(posedge aclk);   // sweep after reset
        foreach (dir_cmd[i]) begin
            send_item(dir_cmd[i], 1'b1);
            if (dir_has_want[i]) begin
                // typed value must agree with the map; it replaces the entry just queued
                void'(pending_reports.pop_back());
                pending_reports.push_back(dir_want[i]);
            end
        end

        // Random phases, each with its own threshold, extremes included.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: drain_then_config(16'h8000);
                1: drain_then_config(16'h7FFF);
                2: drain_then_config(16'h0000);
                3: drain_then_config(16'hFFCE);
                default: drain_then_config(16'd100);
            endcase
            if (phase == 0) hold_off = 1'b1;   // receiver stalls long while items keep coming
            for (int n = 0; n < 110; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 110; b++, n++) begin
                    c = random_cmd();
                    send_item(c, 1'b0);
                end
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        stim_done = 1'b1;
    end

    // Receiver: own stall pattern, plus one long hold-off when asked.
    initial begin
        int cnt;
        bit held;
        m_tready = 1'b0;
        cnt = 0;
        held = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            cnt++;
            if (hold_off && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (1500) @(posedge aclk);
            end else if ((cnt / 64) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        cell_report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[8:0], m_tdata[17:9], m_tdata[33:18],
                   m_tdata[51:34], m_tdata[52]};
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected item status", got.status, -1);
            end else begin
                want = pending_reports.pop_front();
                if (got.status != want.status) report_mismatch("status", got.status, want.status);
                if (got.row != want.row) report_mismatch("cell_row", got.row, want.row);
                if (got.col != want.col) report_mismatch("cell_col", got.col, want.col);
                if (got.mean != want.mean)
                    report_mismatch("mean_mm", $signed(got.mean), $signed(want.mean));
                if (got.count != want.count)
                    report_mismatch("point_count", got.count, want.count);
                if (got.obstacle != want.obstacle)
                    report_mismatch("obstacle", got.obstacle, want.obstacle);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        fork
            begin
                wait (stim_done);
                while (pending_reports.size() != 0) @(posedge aclk);
                repeat (200) @(posedge aclk);
            end
            begin
                @(posedge aclk);
                while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
                $display("watchdog expired");
                errors++;
            end
        join_any
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
